// ===== hw/rtl/wpd_pkg.sv =====
// package for the worker pool dispatcher: sizes, codes, beat and command types
// used by every module of the block, depends on nothing else
package wpd_pkg;

  localparam int unsigned MaxBarbers = 16;
  localparam int unsigned MaxSeats   = 16;
  localparam int unsigned CustBits   = 8;

  localparam int unsigned BarberW  = $clog2(MaxBarbers);
  localparam int unsigned SeatW    = $clog2(MaxSeats);
  localparam int unsigned BCountW  = $clog2(MaxBarbers + 1);
  localparam int unsigned SCountW  = $clog2(MaxSeats + 1);
  localparam int unsigned CfgW     = 5;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgBarbers = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSeats   = 1'b1;

  localparam logic [CfgW-1:0] BarbersReset = 5'd1;
  localparam logic [CfgW-1:0] SeatsReset   = 5'd4;

  typedef enum logic [1:0] {
    ACT_ARRIVE  = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_FINISH  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_DIRECT  = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_AWAY    = 3'd2,
    ST_IDLES   = 3'd3,
    ST_STARTS  = 3'd4,
    ST_DONE    = 3'd5,
    ST_INVALID = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [CustBits-1:0] customer_id;
    logic [BarberW-1:0]  worker_id;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [CustBits-1:0] served_customer;
    logic [BarberW-1:0]  served_barber;
    logic [SCountW-1:0]  queue_count;
    logic [BCountW-1:0]  idle_count;
  } out_item_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [CustBits-1:0] cust;
  } wait_cmd_t;

  typedef struct packed {
    logic [SCountW-1:0]  count;
    logic [CustBits-1:0] head_cust;
  } wait_stat_t;

  typedef struct packed {
    logic                free_push;
    logic                free_pop;
    logic                assign_cust;
    logic                release_cust;
    logic [BarberW-1:0]  target_id;
    logic [CustBits-1:0] cust;
  } worker_cmd_t;

  typedef struct packed {
    logic [BCountW-1:0]  idle_count;
    logic [BarberW-1:0]  free_first_id;
    logic                sel_idle;
    logic                sel_busy;
    logic [CustBits-1:0] sel_client;
  } worker_stat_t;

endpackage

// ===== hw/rtl/wpd_wait_queue.sv =====
// circular fifo of waiting customers with head, tail and fill count
// depends on wpd_pkg
module wpd_wait_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpd_pkg::wait_cmd_t  cmd_i,
  output wpd_pkg::wait_stat_t stat_o
);

  logic [wpd_pkg::CustBits-1:0] slots_q [wpd_pkg::MaxSeats];
  logic [wpd_pkg::SeatW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [wpd_pkg::SCountW-1:0]  count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.push) begin
      tail_d  = (tail_q == wpd_pkg::SeatW'(wpd_pkg::MaxSeats - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d  = (head_q == wpd_pkg::SeatW'(wpd_pkg::MaxSeats - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      slots_q[tail_q] <= cmd_i.cust;
    end
  end

  assign stat_o.count     = count_q;
  assign stat_o.head_cust = slots_q[head_q];

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> count_q < wpd_pkg::SCountW'(wpd_pkg::MaxSeats))
    else $error("push into full wait fifo");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("pop from empty wait fifo");

  a_push_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && !cmd_i.pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("wait count missed a push");

endmodule

// ===== hw/rtl/wpd_worker_table.sv =====
// idle worker fifo plus per-worker busy, idle and customer registers
// depends on wpd_pkg
module wpd_worker_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wpd_pkg::worker_cmd_t           cmd_i,
  input  logic [wpd_pkg::BarberW-1:0]    lookup_id_i,
  output wpd_pkg::worker_stat_t          stat_o
);

  logic [wpd_pkg::BarberW-1:0]  idle_ids_q [wpd_pkg::MaxBarbers];
  logic [wpd_pkg::CustBits-1:0] client_q [wpd_pkg::MaxBarbers];
  logic [wpd_pkg::MaxBarbers-1:0] busy_q, busy_d, idle_q, idle_d;
  logic [wpd_pkg::BarberW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [wpd_pkg::BCountW-1:0]  count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    busy_d  = busy_q;
    idle_d  = idle_q;
    if (cmd_i.free_push) begin
      tail_d  = (tail_q == wpd_pkg::BarberW'(wpd_pkg::MaxBarbers - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
      idle_d[cmd_i.target_id] = 1'b1;
    end
    if (cmd_i.free_pop) begin
      head_d  = (head_q == wpd_pkg::BarberW'(wpd_pkg::MaxBarbers - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.assign_cust) begin
      busy_d[cmd_i.target_id] = 1'b1;
      idle_d[cmd_i.target_id] = 1'b0;
    end
    if (cmd_i.release_cust) begin
      busy_d[cmd_i.target_id] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      busy_q  <= '0;
      idle_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.free_push) begin
      idle_ids_q[tail_q] <= cmd_i.target_id;
    end
    if (cmd_i.assign_cust) begin
      client_q[cmd_i.target_id] <= cmd_i.cust;
    end
  end

  assign stat_o.idle_count    = count_q;
  assign stat_o.free_first_id = idle_ids_q[head_q];
  assign stat_o.sel_idle      = idle_q[lookup_id_i];
  assign stat_o.sel_busy      = busy_q[lookup_id_i];
  assign stat_o.sel_client    = client_q[lookup_id_i];

  a_no_idle_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free_pop |-> count_q != '0)
    else $error("pop from empty idle fifo");

  a_idle_flags_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(idle_q) <= count_q)
    else $error("more idle flags than idle fifo entries");

  a_assigned_is_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.assign_cust |=> busy_q[$past(cmd_i.target_id)])
    else $error("assigned worker not marked busy");

endmodule

// ===== hw/rtl/wpd_decide.sv =====
// per-event dispatch decision: fifo and worker commands and the result beat
// depends on wpd_pkg
module wpd_decide (
  input  logic                       fire_i,
  input  wpd_pkg::in_item_t           item_i,
  input  logic [wpd_pkg::CfgW-1:0]    barbers_i,
  input  logic [wpd_pkg::CfgW-1:0]    seats_i,
  input  wpd_pkg::wait_stat_t         wait_stat_i,
  input  wpd_pkg::worker_stat_t       worker_stat_i,
  output wpd_pkg::wait_cmd_t          wait_cmd_o,
  output wpd_pkg::worker_cmd_t        worker_cmd_o,
  output wpd_pkg::out_item_t          result_o
);

  logic [wpd_pkg::BCountW-1:0] eff_barbers;
  logic [wpd_pkg::SCountW-1:0] eff_seats;
  logic                        bid_ok;
  wpd_pkg::wait_cmd_t          wcmd;
  wpd_pkg::worker_cmd_t        kcmd;

  always_comb begin
    if (barbers_i == '0) begin
      eff_barbers = wpd_pkg::BCountW'(1);
    end else if (barbers_i > wpd_pkg::CfgW'(wpd_pkg::MaxBarbers)) begin
      eff_barbers = wpd_pkg::BCountW'(wpd_pkg::MaxBarbers);
    end else begin
      eff_barbers = wpd_pkg::BCountW'(barbers_i);
    end
    if (seats_i > wpd_pkg::CfgW'(wpd_pkg::MaxSeats)) begin
      eff_seats = wpd_pkg::SCountW'(wpd_pkg::MaxSeats);
    end else begin
      eff_seats = wpd_pkg::SCountW'(seats_i);
    end
  end

  assign bid_ok = wpd_pkg::BCountW'(item_i.worker_id) < eff_barbers;

  always_comb begin
    wcmd      = '0;
    wcmd.cust = item_i.customer_id;
    kcmd           = '0;
    kcmd.target_id = item_i.worker_id;
    kcmd.cust      = item_i.customer_id;
    result_o.status          = wpd_pkg::ST_INVALID;
    result_o.served_customer = '0;
    result_o.served_barber   = item_i.worker_id;
    case (item_i.action)
      wpd_pkg::ACT_ARRIVE: begin
        result_o.served_customer = item_i.customer_id;
        if (worker_stat_i.idle_count != '0) begin
          kcmd.free_pop           = 1'b1;
          kcmd.assign_cust        = 1'b1;
          kcmd.target_id          = worker_stat_i.free_first_id;
          result_o.status         = wpd_pkg::ST_DIRECT;
          result_o.served_barber  = worker_stat_i.free_first_id;
        end else if (eff_seats == '0 || wait_stat_i.count >= eff_seats) begin
          result_o.status        = wpd_pkg::ST_AWAY;
          result_o.served_barber = '0;
        end else begin
          wcmd.push              = 1'b1;
          result_o.status        = wpd_pkg::ST_QUEUED;
          result_o.served_barber = '0;
        end
      end
      wpd_pkg::ACT_REQUEST: begin
        if (bid_ok && !worker_stat_i.sel_idle) begin
          if (worker_stat_i.sel_busy) begin
            result_o.status          = wpd_pkg::ST_STARTS;
            result_o.served_customer = worker_stat_i.sel_client;
          end else if (wait_stat_i.count != '0) begin
            wcmd.pop                 = 1'b1;
            kcmd.assign_cust         = 1'b1;
            kcmd.cust                = wait_stat_i.head_cust;
            result_o.status          = wpd_pkg::ST_STARTS;
            result_o.served_customer = wait_stat_i.head_cust;
          end else if (worker_stat_i.idle_count < eff_barbers) begin
            kcmd.free_push  = 1'b1;
            result_o.status = wpd_pkg::ST_IDLES;
          end
        end
      end
      wpd_pkg::ACT_FINISH: begin
        if (bid_ok && worker_stat_i.sel_busy) begin
          kcmd.release_cust        = 1'b1;
          result_o.status          = wpd_pkg::ST_DONE;
          result_o.served_customer = worker_stat_i.sel_client;
        end
      end
      default: begin
        result_o.status = wpd_pkg::ST_INVALID;
      end
    endcase

    if (wcmd.push) begin
      result_o.queue_count = wait_stat_i.count + 1'b1;
    end else if (wcmd.pop) begin
      result_o.queue_count = wait_stat_i.count - 1'b1;
    end else begin
      result_o.queue_count = wait_stat_i.count;
    end
    if (kcmd.free_push) begin
      result_o.idle_count = worker_stat_i.idle_count + 1'b1;
    end else if (kcmd.free_pop) begin
      result_o.idle_count = worker_stat_i.idle_count - 1'b1;
    end else begin
      result_o.idle_count = worker_stat_i.idle_count;
    end

    wait_cmd_o   = fire_i ? wcmd : '0;
    worker_cmd_o = fire_i ? kcmd : '0;
  end

endmodule

// ===== hw/rtl/worker_pool_dispatcher.sv =====
// worker pool dispatcher top level: input register, result register, config
// depends on wpd_pkg, wpd_wait_queue, wpd_worker_table, wpd_decide
//
// events come in on the in_* channel (valid/ready), one beat per event:
// a customer arrival, a worker asking for work or a worker finishing.
// every event gives exactly one result beat on the out_* channel with the
// status, the customer and worker concerned and both fifo fill counts.
// an accepted beat lands in the input register; once the result register
// is empty or taken by the receiver, the dispatch logic reads the wait
// fifo head, the idle fifo head and the worker flags, updates them and
// loads the result register. one beat per cycle is sustained while the
// receiver does not stall, set by the single fifo read-modify-write per event.
// when the receiver stalls, the result register holds and the input
// register holds one more beat; in_ready_o then falls until out_ready_i.
// reset empties both fifos, clears all worker flags and sets the config
// registers to one worker and four seats. config writes take effect at
// once and are meant for idle periods only.
module worker_pool_dispatcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wpd_pkg::in_item_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wpd_pkg::out_item_t             out_item_o,
  input  logic                          cfg_we_i,
  input  logic [wpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wpd_pkg::CfgW-1:0]      cfg_wdata_i
);

  logic [wpd_pkg::CfgW-1:0] barbers_q, seats_q;
  logic                     in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  wpd_pkg::in_item_t        in_item_q;
  wpd_pkg::out_item_t       out_item_q, result;
  logic                     advance;
  wpd_pkg::wait_cmd_t       wait_cmd;
  wpd_pkg::wait_stat_t      wait_stat;
  wpd_pkg::worker_cmd_t     worker_cmd;
  wpd_pkg::worker_stat_t    worker_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      barbers_q <= wpd_pkg::BarbersReset;
      seats_q   <= wpd_pkg::SeatsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wpd_pkg::CfgBarbers: barbers_q <= cfg_wdata_i;
        wpd_pkg::CfgSeats:   seats_q   <= cfg_wdata_i;
        default: begin
          barbers_q <= barbers_q;
        end
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  wpd_decide u_decide (
    .fire_i        (advance),
    .item_i        (in_item_q),
    .barbers_i     (barbers_q),
    .seats_i       (seats_q),
    .wait_stat_i   (wait_stat),
    .worker_stat_i (worker_stat),
    .wait_cmd_o    (wait_cmd),
    .worker_cmd_o  (worker_cmd),
    .result_o      (result)
  );

  wpd_wait_queue u_wait_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (wait_cmd),
    .stat_o (wait_stat)
  );

  wpd_worker_table u_worker_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (worker_cmd),
    .lookup_id_i (in_item_q.worker_id),
    .stat_o      (worker_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/worker_pool_dispatcher_test.sv =====
// testbench for worker_pool_dispatcher: directed and random events, results
// predicted by a dispatcher model kept in the bench and checked beat by beat
// depends on wpd_pkg and the rtl of the block
module worker_pool_dispatcher_test;

  localparam logic [1:0]  ActUnknown    = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseEvents   = 75;
  localparam int unsigned NumPhases     = 8;

  class dispatch_tracker;
    logic [wpd_pkg::CfgW-1:0]     barbers_reg;
    logic [wpd_pkg::CfgW-1:0]     seats_reg;
    logic [wpd_pkg::CustBits-1:0] seat_cust [wpd_pkg::MaxSeats];
    logic [wpd_pkg::SeatW-1:0]    seat_head;
    logic [wpd_pkg::SeatW-1:0]    seat_tail;
    logic [wpd_pkg::SCountW-1:0]  seat_cnt;
    logic [wpd_pkg::BarberW-1:0]  idle_fifo [wpd_pkg::MaxBarbers];
    logic [wpd_pkg::BarberW-1:0]  free_rd;
    logic [wpd_pkg::BarberW-1:0]  free_wr;
    logic [wpd_pkg::BCountW-1:0]  idle_cnt;
    logic [wpd_pkg::CustBits-1:0] client [wpd_pkg::MaxBarbers];
    bit                           busy [wpd_pkg::MaxBarbers];
    bit                           idling [wpd_pkg::MaxBarbers];
    wpd_pkg::out_item_t           due_results [$];
    int                           errors;

    function new();
      barbers_reg = wpd_pkg::BarbersReset;
      seats_reg   = wpd_pkg::SeatsReset;
      seat_head   = '0;
      seat_tail   = '0;
      seat_cnt    = '0;
      free_rd     = '0;
      free_wr     = '0;
      idle_cnt    = '0;
      errors      = 0;
      for (int i = 0; i < wpd_pkg::MaxBarbers; i++) begin
        client[i] = '0;
        busy[i]   = 1'b0;
        idling[i] = 1'b0;
      end
    endfunction

    function void write_reg(logic [wpd_pkg::CfgIdxW-1:0] idx, logic [wpd_pkg::CfgW-1:0] val);
      if (idx == wpd_pkg::CfgBarbers) begin
        barbers_reg = val;
      end else begin
        seats_reg = val;
      end
    endfunction

    function int unsigned workers();
      if (barbers_reg == 0) return 1;
      if (barbers_reg > wpd_pkg::MaxBarbers) return wpd_pkg::MaxBarbers;
      return 32'(barbers_reg);
    endfunction

    function int unsigned seats();
      if (seats_reg > wpd_pkg::MaxSeats) return wpd_pkg::MaxSeats;
      return 32'(seats_reg);
    endfunction

    function void note_event(wpd_pkg::in_item_t ev);
      wpd_pkg::out_item_t          want;
      logic [wpd_pkg::BarberW-1:0] b;
      want.status          = wpd_pkg::ST_INVALID;
      want.served_customer = '0;
      want.served_barber   = ev.worker_id;
      b = ev.worker_id;
      case (ev.action)
        wpd_pkg::ACT_ARRIVE: begin
          want.served_customer = ev.customer_id;
          if (idle_cnt > 0) begin
            b = idle_fifo[free_rd];
            free_rd   = free_rd + 1'b1;
            idle_cnt  = idle_cnt - 1'b1;
            idling[b] = 1'b0;
            client[b] = ev.customer_id;
            busy[b]   = 1'b1;
            want.status        = wpd_pkg::ST_DIRECT;
            want.served_barber = b;
          end else if (seats() == 0 || seat_cnt >= seats()) begin
            want.status        = wpd_pkg::ST_AWAY;
            want.served_barber = '0;
          end else begin
            seat_cust[seat_tail] = ev.customer_id;
            seat_tail = seat_tail + 1'b1;
            seat_cnt  = seat_cnt + 1'b1;
            want.status        = wpd_pkg::ST_QUEUED;
            want.served_barber = '0;
          end
        end
        wpd_pkg::ACT_REQUEST: begin
          if (b < workers() && !idling[b]) begin
            if (busy[b]) begin
              want.status          = wpd_pkg::ST_STARTS;
              want.served_customer = client[b];
            end else if (seat_cnt > 0) begin
              client[b] = seat_cust[seat_head];
              busy[b]   = 1'b1;
              seat_head = seat_head + 1'b1;
              seat_cnt  = seat_cnt - 1'b1;
              want.status          = wpd_pkg::ST_STARTS;
              want.served_customer = client[b];
            end else if (idle_cnt < workers()) begin
              idle_fifo[free_wr] = b;
              free_wr   = free_wr + 1'b1;
              idle_cnt  = idle_cnt + 1'b1;
              idling[b] = 1'b1;
              want.status = wpd_pkg::ST_IDLES;
            end
          end
        end
        wpd_pkg::ACT_FINISH: begin
          if (b < workers() && busy[b]) begin
            want.status          = wpd_pkg::ST_DONE;
            want.served_customer = client[b];
            busy[b]   = 1'b0;
            client[b] = '0;
          end
        end
        default: ;
      endcase
      want.queue_count = seat_cnt;
      want.idle_count  = idle_cnt;
      due_results.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(wpd_pkg::out_item_t got);
      wpd_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result beat with nothing pending, status %0d", got.status));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.served_customer !== want.served_customer)
        report($sformatf("customer %0d, want %0d", got.served_customer,
                         want.served_customer));
      if (got.served_barber !== want.served_barber)
        report($sformatf("barber %0d, want %0d", got.served_barber, want.served_barber));
      if (got.queue_count !== want.queue_count)
        report($sformatf("queue count %0d, want %0d", got.queue_count, want.queue_count));
      if (got.idle_count !== want.idle_count)
        report($sformatf("idle count %0d, want %0d", got.idle_count, want.idle_count));
    endtask
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  wpd_pkg::in_item_t            in_item_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  wpd_pkg::out_item_t           out_item_o;
  logic                         cfg_we_i;
  logic [wpd_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [wpd_pkg::CfgW-1:0]     cfg_wdata_i;

  dispatch_tracker sb;
  bit              tx_steady = 1'b0;
  bit              rx_steady = 1'b0;
  int              idle_cycles = 0;
  int              phase_barbers [NumPhases] = '{16, 1, 4, 0, 31, 7, 16, 2};
  int              phase_seats [NumPhases]   = '{16, 0, 2, 31, 3, 16, 1, 5};

  worker_pool_dispatcher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function wpd_pkg::in_item_t make_event(logic [1:0] act,
                                         logic [wpd_pkg::CustBits-1:0] cust,
                                         logic [wpd_pkg::BarberW-1:0] bid);
    wpd_pkg::in_item_t ev;
    ev.action      = act;
    ev.customer_id = cust;
    ev.worker_id   = bid;
    return ev;
  endfunction

  function wpd_pkg::in_item_t random_event();
    wpd_pkg::in_item_t ev;
    int unsigned       pick;
    int                held [$];
    ev.customer_id = wpd_pkg::CustBits'($urandom_range(0, 255));
    ev.worker_id   = wpd_pkg::BarberW'($urandom_range(0, wpd_pkg::MaxBarbers - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      ev.action = ActUnknown;
    end else if (pick < 42) begin
      ev.action = wpd_pkg::ACT_ARRIVE;
    end else if (pick < 75) begin
      ev.action = wpd_pkg::ACT_REQUEST;
      if ($urandom_range(0, 9) != 0)
        ev.worker_id = wpd_pkg::BarberW'($urandom_range(0, sb.workers() - 1));
    end else begin
      ev.action = wpd_pkg::ACT_FINISH;
      for (int i = 0; i < sb.workers(); i++) if (sb.busy[i]) held.push_back(i);
      if (held.size() > 0 && $urandom_range(0, 9) < 8)
        ev.worker_id = wpd_pkg::BarberW'(held[$urandom_range(0, held.size() - 1)]);
    end
    return ev;
  endfunction

  task send_event(input wpd_pkg::in_item_t ev);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= ev;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_event(ev);
  endtask

  task set_config(input logic [wpd_pkg::CfgW-1:0] nb, input logic [wpd_pkg::CfgW-1:0] ns);
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= wpd_pkg::CfgBarbers;
    cfg_wdata_i <= nb;
    @(posedge clk_i);
    sb.write_reg(wpd_pkg::CfgBarbers, nb);
    cfg_index_i <= wpd_pkg::CfgSeats;
    cfg_wdata_i <= ns;
    @(posedge clk_i);
    sb.write_reg(wpd_pkg::CfgSeats, ns);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_item_o);
    end
  end

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(5'd3, 5'd1);
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'hFF, 4'd2));
    send_event(make_event(wpd_pkg::ACT_ARRIVE, 8'hFF, 4'd0));
    send_event(make_event(wpd_pkg::ACT_ARRIVE, 8'h00, 4'd15));
    send_event(make_event(wpd_pkg::ACT_ARRIVE, 8'h5A, 4'd0));
    send_event(make_event(wpd_pkg::ACT_ARRIVE, 8'hA5, 4'd0));
    // assigned customer comes back ahead of the queued one
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_FINISH, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_FINISH, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd3));
    send_event(make_event(ActUnknown, 8'hFF, 4'd15));
    send_event(make_event(wpd_pkg::ACT_FINISH, 8'h00, 4'd2));
    send_event(make_event(wpd_pkg::ACT_FINISH, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd2));
    // capacity lowered to the idle fill
    set_config(5'd2, 5'd1);
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd0));
    send_event(make_event(wpd_pkg::ACT_ARRIVE, 8'h11, 4'd0));
    send_event(make_event(wpd_pkg::ACT_ARRIVE, 8'h22, 4'd0));
    set_config(5'd2, 5'd0);
    send_event(make_event(wpd_pkg::ACT_ARRIVE, 8'h33, 4'd0));
    set_config(5'd0, 5'd0);
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd1));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd0));
    set_config(5'd31, 5'd31);
    send_event(make_event(wpd_pkg::ACT_FINISH, 8'h00, 4'd15));
    send_event(make_event(wpd_pkg::ACT_REQUEST, 8'h00, 4'd15));

    for (int p = 0; p < NumPhases; p++) begin
      set_config(wpd_pkg::CfgW'(phase_barbers[p]), wpd_pkg::CfgW'(phase_seats[p]));
      repeat (PhaseEvents) send_event(random_event());
    end

    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
